// ===== design/prf_pkg.sv =====
// shared types and constants for the pair rank feedback filter
// no dependencies; imported by every module of the block
package prf_pkg;

  localparam int TABLE_ENTRIES = 1024;  // power of two, slot taken from hash bits
  localparam int MAX_PROBES    = 8;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int PROBE_W       = $clog2(MAX_PROBES);
  localparam int ID_W          = 32;
  localparam int KEY_W         = 2 * ID_W;
  localparam int SUM_W         = 48;
  localparam int CNT_W         = 16;
  localparam int THR_W         = 40;
  localparam int EPOCH_W       = 16;
  localparam int TAG_W         = 8;
  localparam int EXCL_W        = 32;
  localparam int MUL_A_W       = 40;
  localparam int MUL_B_W       = 32;
  localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
  localparam int HASH_LSB      = 32;

  localparam logic [31:0] HASH_HI = 32'h9E3779B9;
  localparam logic [31:0] HASH_LO = 32'h7F4A7C15;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MIN_FULL  = 2'd1;
  localparam logic [1:0] REG_EPOCH     = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] key;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } tab_ctl_t;

endpackage

// ===== design/prf_mul.sv =====
// shared multiplier for key hashing and threshold products
// depends on prf_pkg
module prf_mul import prf_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule

// ===== design/prf_tab.sv =====
// one keyed rank table: entry memory with one write and one registered read port
// depends on prf_pkg
module prf_tab import prf_pkg::*; (
  input  logic     clk,
  input  tab_ctl_t ctl,
  output entry_t   rd_data
);

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

endmodule

// ===== design/pair_rank_feedback_filter_unit.sv =====
// top level of the pair rank feedback filter: sequencer, config, output register
// depends on prf_pkg, prf_mul and prf_tab
// sequence: a query gated by epoch goes straight to finish; otherwise per table hash,
//   slot, 1 to MAX_PROBES reads and, on a query hit, a compare; then finish
// requests: one at a time; s_tready is high only in the idle state
// reset: sync, clears control; then a tag clearing pass over all table slots, not ready
//   meanwhile; the same pass recurs every 255th batch start when the tag wraps
module pair_rank_feedback_filter_unit import prf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // slave request channel
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,  // subject_id, predicate_id, object_id, object_rank, subject_rank
  input  logic [1:0]   s_tuser,  // mode, first_of_batch
  // master result channel
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,  // excluded_count
  output logic [1:0]   m_tuser,  // included, table_full
  // config write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [39:0]  cfg_data
);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_HASH = 7'b0000100,
    S_SLOT = 7'b0001000,
    S_RD   = 7'b0010000,
    S_CMP  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state;

  // config registers
  logic [THR_W-1:0]   threshold_q8;
  logic [EPOCH_W-1:0] min_full_epochs;
  logic [EPOCH_W-1:0] current_epoch;

  // latched request
  logic             item_mode;
  logic [ID_W-1:0]  subj, pred, obj, orank, srank;

  // sequencer state
  logic               tsel;       // 0 subject-predicate table, 1 predicate-object
  logic [PROBE_W-1:0] probe;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   hash_small;
  logic [TAG_W-1:0]   epoch;      // batch tag; entries with another tag are empty
  logic [IDX_W-1:0]   clr_cnt;
  logic               clr_ret;    // clearing pass started by a batch start
  logic               incl, full;
  logic [EXCL_W-1:0]  excl_total;
  entry_t             ent;

  // datapath
  logic [KEY_W-1:0]   cur_key;
  logic [ID_W-1:0]    cur_rank, key_lo, key_hi;
  entry_t             rd_sp, rd_po, rd_cur;
  tab_ctl_t           ctl_sp, ctl_po, ctl;
  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [IDX_W-1:0]   slot_calc;
  logic               ent_valid, key_hit, below;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_sat;
  logic [CNT_W-1:0]   cnt_sat;

  assign key_hi   = tsel ? pred : subj;
  assign key_lo   = tsel ? obj  : pred;
  assign cur_key  = {key_hi, key_lo};
  assign cur_rank = tsel ? srank : orank;
  assign rd_cur   = tsel ? rd_po : rd_sp;

  assign s_tready = (state == S_IDLE);

  // bits of the 64-bit hash product that pick the slot
  assign slot_calc = mul_p[HASH_LSB +: IDX_W] + hash_small;

  assign ent_valid = (rd_cur.tag == epoch);
  assign key_hit   = (rd_cur.key == cur_key);
  assign sum_add   = {1'b0, rd_cur.sum} + (SUM_W+1)'(cur_rank);
  assign sum_sat   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign cnt_sat   = (rd_cur.count == {CNT_W{1'b1}}) ? rd_cur.count : rd_cur.count + 1'b1;
  // exact average test without division
  assign below     = ({ent.sum, 8'h00} < mul_p[SUM_W+7:0]);

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = MUL_A_W'(key_lo);
    mul_b  = HASH_LO;
    if (state == S_HASH) begin
      mul_en = 1'b1;
    end else if (state == S_RD && item_mode && ent_valid && key_hit) begin
      mul_en = 1'b1;
      mul_a  = threshold_q8;
      mul_b  = MUL_B_W'(rd_cur.count);
    end
  end

  // table port control
  always_comb begin
    ctl = '0;
    ctl.rd_addr = (state == S_SLOT) ? slot_calc : slot + 1'b1;
    ctl.wr_addr = slot;
    ctl.rd_en   = (state == S_SLOT) ||
                  (state == S_RD && ent_valid && !key_hit &&
                   probe != PROBE_W'(MAX_PROBES-1));
    if (state == S_CLR) begin
      ctl.wr_en   = 1'b1;
      ctl.wr_addr = clr_cnt;
    end else if (state == S_RD && !item_mode) begin
      if (!ent_valid) begin
        ctl.wr_en   = 1'b1;
        ctl.wr_data = '{tag: epoch, key: cur_key, sum: SUM_W'(cur_rank), count: CNT_W'(1)};
      end else if (key_hit) begin
        ctl.wr_en   = 1'b1;
        ctl.wr_data = '{tag: epoch, key: cur_key, sum: sum_sat, count: cnt_sat};
      end
    end
  end

  always_comb begin
    ctl_sp = ctl;
    ctl_po = ctl;
    ctl_sp.rd_en = ctl.rd_en && !tsel;
    ctl_po.rd_en = ctl.rd_en && tsel;
    ctl_sp.wr_en = ctl.wr_en && (state == S_CLR || !tsel);
    ctl_po.wr_en = ctl.wr_en && (state == S_CLR || tsel);
  end

  prf_mul u_mul (.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .p(mul_p));
  prf_tab u_sp  (.clk(clk), .ctl(ctl_sp), .rd_data(rd_sp));
  prf_tab u_po  (.clk(clk), .ctl(ctl_po), .rd_data(rd_po));

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_q8    <= '0;
      min_full_epochs <= '0;
      current_epoch   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold_q8    <= cfg_data[THR_W-1:0];
        REG_MIN_FULL:  min_full_epochs <= cfg_data[EPOCH_W-1:0];
        REG_EPOCH:     current_epoch   <= cfg_data[EPOCH_W-1:0];
        default: ;
      endcase
    end
  end

  // latched request fields
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_mode <= s_tuser[0];
      subj      <= s_tdata[31:0];
      pred      <= s_tdata[63:32];
      obj       <= s_tdata[95:64];
      orank     <= s_tdata[127:96];
      srank     <= s_tdata[159:128];
    end
    if (state == S_RD && item_mode && ent_valid && key_hit) begin
      ent <= rd_cur;
    end
    if (state == S_HASH) begin
      // low bits of the cross terms of the 64 by 64 hash product
      hash_small <= IDX_W'(key_hi[IDX_W-1:0] * HASH_LO[IDX_W-1:0]) +
                    IDX_W'(key_lo[IDX_W-1:0] * HASH_HI[IDX_W-1:0]);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      clr_ret    <= 1'b0;
      epoch      <= TAG_W'(1);
      tsel       <= 1'b0;
      probe      <= '0;
      slot       <= '0;
      incl       <= 1'b0;
      full       <= 1'b0;
      excl_total <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // result taken; a new one from the finish state replaces it
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == {IDX_W{1'b1}}) begin
            epoch <= TAG_W'(1);
            state <= clr_ret ? S_HASH : S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            tsel <= 1'b0;
            full <= 1'b0;
            incl <= s_tuser[0];
            if (!s_tuser[0]) begin
              if (s_tuser[1]) begin
                excl_total <= '0;
              end
              if (s_tuser[1] && epoch == {TAG_W{1'b1}}) begin
                // tag wrapped: wipe both tables before the load
                clr_cnt <= '0;
                clr_ret <= 1'b1;
                state   <= S_CLR;
              end else begin
                if (s_tuser[1]) begin
                  epoch <= epoch + 1'b1;
                end
                state <= S_HASH;
              end
            end else if (current_epoch < min_full_epochs) begin
              state <= S_FIN;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: state <= S_SLOT;
        S_SLOT: begin
          slot  <= slot_calc;
          probe <= '0;
          state <= S_RD;
        end
        S_RD: begin
          if (ent_valid && key_hit && item_mode) begin
            state <= S_CMP;
          end else if (ent_valid && !key_hit && probe != PROBE_W'(MAX_PROBES-1)) begin
            probe <= probe + 1'b1;
            slot  <= slot + 1'b1;
          end else begin
            // table done: inserted, updated, absent or dropped
            if (ent_valid && !key_hit && !item_mode) begin
              full <= 1'b1;
            end
            tsel  <= 1'b1;
            state <= tsel ? S_FIN : S_HASH;
          end
        end
        S_CMP: begin
          if (below) begin
            incl <= 1'b0;
            if (excl_total != {EXCL_W{1'b1}}) begin
              excl_total <= excl_total + 1'b1;
            end
            state <= S_FIN;
          end else begin
            tsel  <= 1'b1;
            state <= tsel ? S_FIN : S_HASH;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= excl_total;
            m_tuser  <= {full, incl};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a threshold compare only follows a query hit
  a_cmp_query: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> item_mode) else $error("compare on a load");

  // a load never reports included, a query never reports a dropped key
  a_load_incl: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !item_mode) |-> !incl) else $error("load marked included");

  a_query_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && item_mode) |-> !full) else $error("query marked full");

  // the probe walk moves one slot per read
  a_probe_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD && $past(state) == S_RD && probe != $past(probe)) |->
    (slot == $past(slot) + 1'b1)) else $error("probe slot skipped");

endmodule
